### rtl/dfa_source_tokenizer_assert.svh
// Assertion macros used by the checker
`ifndef DFA_SOURCE_TOKENIZER_ASSERT_SVH
`define DFA_SOURCE_TOKENIZER_ASSERT_SVH

// Same-cycle implication
`define DST_ASSERT_NOW(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) else $error(msg);

// Next-cycle implication
`define DST_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);

`endif

### rtl/dst_pkg.sv
package dst_pkg;

  localparam int KW_NUM = 14;

  localparam logic [5:0] C_LE     = 6'd0;
  localparam logic [5:0] C_LT     = 6'd1;
  localparam logic [5:0] C_GE     = 6'd2;
  localparam logic [5:0] C_GT     = 6'd3;
  localparam logic [5:0] C_EQ     = 6'd4;
  localparam logic [5:0] C_ASSIGN = 6'd5;
  localparam logic [5:0] C_ADD    = 6'd6;
  localparam logic [5:0] C_SUB    = 6'd7;
  localparam logic [5:0] C_MUL    = 6'd8;
  localparam logic [5:0] C_DIV    = 6'd9;
  localparam logic [5:0] C_MOD    = 6'd10;
  localparam logic [5:0] C_NE     = 6'd11;
  localparam logic [5:0] C_LPAREN = 6'd12;
  localparam logic [5:0] C_RPAREN = 6'd13;
  localparam logic [5:0] C_LSQ    = 6'd14;
  localparam logic [5:0] C_RSQ    = 6'd15;
  localparam logic [5:0] C_LBRACE = 6'd16;
  localparam logic [5:0] C_RBRACE = 6'd17;
  localparam logic [5:0] C_SEMI   = 6'd18;
  localparam logic [5:0] C_COMMA  = 6'd19;
  localparam logic [5:0] C_KW0    = 6'd20;
  localparam logic [5:0] C_ID     = 6'd34;
  localparam logic [5:0] C_INT    = 6'd35;
  localparam logic [5:0] C_STR    = 6'd36;
  localparam logic [5:0] C_CLOSE  = 6'd37;
  localparam logic [5:0] C_END    = 6'd38;
  localparam logic [5:0] C_ERR    = 6'd39;

  // keyword text, right-justified: first char sits in the highest used byte
  localparam logic [3:0] KW_LEN [KW_NUM] = '{
    4'd5, 4'd7, 4'd3, 4'd6, 4'd5, 4'd5, 4'd4, 4'd6, 4'd5, 4'd2, 4'd4, 4'd3, 4'd3, 4'd11
  };
  localparam logic [87:0] KW_TEXT [KW_NUM] = '{
    88'("class"), 88'("extends"), 88'("int"), 88'("string"), 88'("break"),
    88'("print"), 88'("read"), 88'("return"), 88'("super"), 88'("if"),
    88'("else"), 88'("for"), 88'("new"), 88'("constructor")
  };

  typedef struct packed {
    logic [5:0]  code;
    logic [31:0] start;
    logic [15:0] line;
    logic [15:0] len;
    logic [31:0] val;
  } tok_t;

  typedef struct packed {
    logic a_vld;
    logic b_vld;
    tok_t a;
    tok_t b;
  } scan_res_t;

  typedef struct packed {
    tok_t tok;
    logic last;
  } ent_t;

  function automatic logic is_letter(input logic [7:0] c);
    logic [7:0] l;
    l = c | 8'h20;
    return (l >= 8'h61) && (l <= 8'h7a);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0d));
  endfunction

  function automatic logic [KW_NUM-1:0] kw_next(input logic [KW_NUM-1:0] kw,
                                                input logic [15:0] len,
                                                input logic [7:0] c);
    logic [KW_NUM-1:0] m;
    logic [3:0] idx;
    m = kw;
    for (int k = 0; k < KW_NUM; k++) begin
      idx = KW_LEN[k] - 4'd1 - len[3:0];
      if (len >= 16'(KW_LEN[k])) begin
        m[k] = 1'b0;
      end else if (KW_TEXT[k][{idx, 3'b000} +: 8] != c) begin
        m[k] = 1'b0;
      end
    end
    return m;
  endfunction

endpackage

### rtl/dst_scan.sv
module dst_scan
  import dst_pkg::*;
#(
  parameter int POSITION_BITS = 32,
  parameter int LINE_BITS = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       step,
  input  logic [7:0] in_byte,
  input  logic       end_of_input,
  output scan_res_t  res
);

  typedef enum logic [3:0] {
    S_IDLE, S_LT, S_GT, S_EQ, S_BANG, S_STAR, S_SLASH, S_IDENT,
    S_NUMBER, S_STRING, S_LINECOM, S_BLOCK, S_BLOCKSTAR
  } state_t;

  state_t                   state_r, state_nxt;
  logic [POSITION_BITS-1:0] pos_r, pos_nxt, tstart_r, tstart_nxt;
  logic [LINE_BITS-1:0]     line_r, line_nxt, tline_r, tline_nxt;
  logic [15:0]              len_r, len_nxt;
  logic [31:0]              val_r, val_nxt;
  logic [KW_NUM-1:0]        kw_r, kw_nxt;

  logic [63:0] pos_w, tstart_w;
  logic [31:0] line_w, tline_w;
  logic [15:0] len_plus;
  logic [35:0] prod;
  logic [31:0] val_sat;
  logic [5:0]  id_code, flush_code, one_code;
  logic        flush_vld, one_vld, consumed;
  tok_t        flush_tok;

  assign pos_w    = 64'(pos_r);
  assign tstart_w = 64'(tstart_r);
  assign line_w   = 32'(line_r);
  assign tline_w  = 32'(tline_r);
  assign len_plus = (len_r == 16'hffff) ? len_r : len_r + 16'd1;
  assign prod     = ({4'd0, val_r} << 3) + ({4'd0, val_r} << 1) + 36'(in_byte - 8'h30);
  assign val_sat  = (|prod[35:32]) ? 32'hffff_ffff : prod[31:0];

  always_comb begin
    id_code = C_ID;
    for (int k = KW_NUM - 1; k >= 0; k--) begin
      if (kw_r[k] && (len_r == 16'(KW_LEN[k]))) begin
        id_code = C_KW0 + 6'(k);
      end
    end
  end

  always_comb begin
    flush_vld  = 1'b1;
    flush_code = C_ERR;
    unique case (state_r)
      S_LT:     flush_code = C_LT;
      S_GT:     flush_code = C_GT;
      S_EQ:     flush_code = C_ASSIGN;
      S_BANG:   flush_code = C_ERR;
      S_STAR:   flush_code = C_MUL;
      S_SLASH:  flush_code = C_DIV;
      S_IDENT:  flush_code = id_code;
      S_NUMBER: flush_code = C_INT;
      S_STRING: flush_code = C_ERR;
      default:  flush_vld = 1'b0;
    endcase
    flush_tok.code  = flush_code;
    flush_tok.start = tstart_w[31:0];
    flush_tok.line  = tline_w[15:0];
    flush_tok.len   = len_r;
    flush_tok.val   = (state_r == S_NUMBER) ? val_r : 32'd0;
  end

  always_comb begin
    one_vld  = 1'b1;
    one_code = C_ERR;
    unique case (in_byte)
      8'h2b:   one_code = C_ADD;
      8'h2d:   one_code = C_SUB;
      8'h25:   one_code = C_MOD;
      8'h28:   one_code = C_LPAREN;
      8'h29:   one_code = C_RPAREN;
      8'h5b:   one_code = C_LSQ;
      8'h5d:   one_code = C_RSQ;
      8'h7b:   one_code = C_LBRACE;
      8'h7d:   one_code = C_RBRACE;
      8'h3b:   one_code = C_SEMI;
      8'h2c:   one_code = C_COMMA;
      default: one_vld = 1'b0;
    endcase
  end

  always_comb begin
    state_nxt  = state_r;
    pos_nxt    = pos_r;
    line_nxt   = line_r;
    tstart_nxt = tstart_r;
    tline_nxt  = tline_r;
    len_nxt    = len_r;
    val_nxt    = val_r;
    kw_nxt     = kw_r;
    consumed   = 1'b1;
    res        = '0;
    res.a      = flush_tok;

    if (end_of_input) begin
      res.a_vld      = flush_vld;
      res.b_vld      = 1'b1;
      res.b.code     = C_END;
      res.b.start    = pos_w[31:0];
      res.b.line     = line_w[15:0];
      state_nxt      = S_IDLE;
    end else begin
      unique case (state_r)
        S_LT, S_GT, S_EQ, S_BANG: begin
          if (in_byte == 8'h3d) begin
            res.a_vld = 1'b1;
            res.a.len = 16'd2;
            res.a.code = (state_r == S_LT) ? C_LE : (state_r == S_GT) ? C_GE :
                         (state_r == S_EQ) ? C_EQ : C_NE;
            state_nxt = S_IDLE;
          end else begin
            res.a_vld = 1'b1;
            consumed  = 1'b0;
          end
        end
        S_STAR: begin
          res.a_vld = 1'b1;
          if (in_byte == 8'h2f) begin
            res.a.code = C_CLOSE;
            res.a.len  = 16'd2;
            state_nxt  = S_IDLE;
          end else begin
            consumed = 1'b0;
          end
        end
        S_SLASH: begin
          if (in_byte == 8'h2f) begin
            state_nxt = S_LINECOM;
          end else if (in_byte == 8'h2a) begin
            state_nxt = S_BLOCK;
          end else begin
            res.a_vld = 1'b1;
            consumed  = 1'b0;
          end
        end
        S_IDENT: begin
          if (is_letter(in_byte) || is_digit(in_byte) || in_byte == 8'h5f) begin
            kw_nxt  = kw_next(kw_r, len_r, in_byte);
            len_nxt = len_plus;
          end else begin
            res.a_vld = 1'b1;
            consumed  = 1'b0;
          end
        end
        S_NUMBER: begin
          if (is_digit(in_byte)) begin
            val_nxt = val_sat;
            len_nxt = len_plus;
          end else begin
            res.a_vld = 1'b1;
            consumed  = 1'b0;
          end
        end
        S_STRING: begin
          len_nxt = len_plus;
          if (in_byte == 8'h22) begin
            res.a_vld  = 1'b1;
            res.a.code = C_STR;
            res.a.len  = len_plus;
            state_nxt  = S_IDLE;
          end
        end
        S_LINECOM: begin
          if (in_byte == 8'h0a) begin
            state_nxt = S_IDLE;
          end
        end
        S_BLOCK: begin
          if (in_byte == 8'h2a) begin
            state_nxt = S_BLOCKSTAR;
          end
        end
        S_BLOCKSTAR: begin
          if (in_byte == 8'h2f) begin
            state_nxt = S_IDLE;
          end else if (in_byte != 8'h2a) begin
            state_nxt = S_BLOCK;
          end
        end
        default: consumed = 1'b0;
      endcase

      if (!consumed) begin
        state_nxt   = S_IDLE;
        tstart_nxt  = pos_r;
        tline_nxt   = line_r;
        len_nxt     = 16'd1;
        val_nxt     = 32'd0;
        kw_nxt      = '1;
        res.b.start = pos_w[31:0];
        res.b.line  = line_w[15:0];
        res.b.len   = 16'd1;
        res.b.code  = one_code;
        unique case (in_byte)
          8'h3c: state_nxt = S_LT;
          8'h3e: state_nxt = S_GT;
          8'h3d: state_nxt = S_EQ;
          8'h21: state_nxt = S_BANG;
          8'h2a: state_nxt = S_STAR;
          8'h2f: state_nxt = S_SLASH;
          8'h22: state_nxt = S_STRING;
          default: begin
            if (one_vld) begin
              res.b_vld = 1'b1;
            end else if (is_letter(in_byte) || in_byte == 8'h5f) begin
              kw_nxt    = kw_next('1, 16'd0, in_byte);
              state_nxt = S_IDENT;
            end else if (is_digit(in_byte)) begin
              val_nxt   = 32'(in_byte - 8'h30);
              state_nxt = S_NUMBER;
            end else if (!is_space(in_byte)) begin
              res.b_vld  = 1'b1;
              res.b.code = C_ERR;
            end
          end
        endcase
      end

      pos_nxt = pos_r + 1'b1;
      if (in_byte == 8'h0a && line_r != '1) begin
        line_nxt = line_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      pos_r    <= '0;
      line_r   <= LINE_BITS'(1);
      tstart_r <= '0;
      tline_r  <= LINE_BITS'(1);
      len_r    <= '0;
      val_r    <= '0;
      kw_r     <= '1;
    end else if (step) begin
      state_r  <= state_nxt;
      pos_r    <= pos_nxt;
      line_r   <= line_nxt;
      tstart_r <= tstart_nxt;
      tline_r  <= tline_nxt;
      len_r    <= len_nxt;
      val_r    <= val_nxt;
      kw_r     <= kw_nxt;
    end
  end

endmodule

### rtl/dfa_source_tokenizer.sv
// channel | dir | handshake          | payload
// in_     | in  | in_tvalid/tready   | tdata: in_byte; tuser: end_of_input
// out_    | out | out_tvalid/tready  | tdata: token fields; tlast: last_of_run
// One byte per cycle is taken; its tokens are written to the result queue at
// the transaction and reach the output behind any older ones. An item that
// closes a pending token and also yields a token of its own (one-character
// token, error byte, or the end token) gives two tokens, which leave in turn.
// Tokens wait in a four-entry result queue; input stalls when fewer than two
// entries are free. Reset (synchronous, rst_n low) empties the queue and
// returns the scanner to idle at position 0, line 1.
module dfa_source_tokenizer
  import dst_pkg::*;
#(
  parameter int POSITION_BITS = 32,
  parameter int LINE_BITS = 16
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [7:0]   in_tdata,   // [7:0] in_byte
  input  logic         in_tuser,   // [0] end_of_input
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [103:0] out_tdata,  // code[5:0] start_pos line_number lexeme_length int_value
  output logic         out_tlast   // last_of_run
);

  scan_res_t  res;
  logic       step, pop;
  ent_t       q_r [4];
  logic [1:0] wp_r, rp_r;
  logic [2:0] cnt_r;
  logic [1:0] n_push;
  ent_t       e0, e1;

  assign in_tready  = (cnt_r <= 3'd2);
  assign step       = in_tvalid & in_tready;
  assign out_tvalid = (cnt_r != 3'd0);
  assign pop        = out_tvalid & out_tready;

  dst_scan #(
    .POSITION_BITS(POSITION_BITS),
    .LINE_BITS(LINE_BITS)
  ) u_scan (
    .clk(clk),
    .rst_n(rst_n),
    .step(step),
    .in_byte(in_tdata),
    .end_of_input(in_tuser),
    .res(res)
  );

  assign e0.tok  = res.a_vld ? res.a : res.b;
  assign e0.last = ~(res.a_vld & res.b_vld);
  assign e1.tok  = res.b;
  assign e1.last = 1'b1;
  assign n_push  = step ? (2'(res.a_vld) + 2'(res.b_vld)) : 2'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (n_push != 2'd0) begin
        q_r[wp_r] <= e0;
      end
      if (n_push == 2'd2) begin
        q_r[wp_r + 2'd1] <= e1;
      end
      wp_r  <= wp_r + n_push;
      rp_r  <= rp_r + 2'(pop);
      cnt_r <= cnt_r + 3'(n_push) - 3'(pop);
    end
  end

  assign out_tdata = {2'b00, q_r[rp_r].tok.val, q_r[rp_r].tok.len, q_r[rp_r].tok.line,
                      q_r[rp_r].tok.start, q_r[rp_r].tok.code};
  assign out_tlast = q_r[rp_r].last;

endmodule

### rtl/dst_checker.sv
`include "dfa_source_tokenizer_assert.svh"
module dst_checker
  import dst_pkg::*;
(
  input logic         clk,
  input logic         rst_n,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [103:0] out_tdata,
  input logic         out_tlast
);

  logic [5:0]  tok_code;
  logic [15:0] tok_len;
  logic [31:0] tok_val;

  assign tok_code = out_tdata[5:0];
  assign tok_len  = out_tdata[69:54];
  assign tok_val  = out_tdata[101:70];

  `DST_ASSERT_NEXT(a_hold, out_tvalid && !out_tready, out_tvalid, "result dropped while stalled")
  `DST_ASSERT_NOW(a_code, out_tvalid, tok_code <= C_ERR, "token code out of range")
  `DST_ASSERT_NOW(a_end_last, out_tvalid && tok_code == C_END, out_tlast && tok_len == 16'd0, "end token malformed")
  `DST_ASSERT_NOW(a_val, out_tvalid && tok_code != C_INT, tok_val == 32'd0, "value on non-integer token")

endmodule

bind dfa_source_tokenizer dst_checker u_dst_checker (
  .clk(clk),
  .rst_n(rst_n),
  .out_tvalid(out_tvalid),
  .out_tready(out_tready),
  .out_tdata(out_tdata),
  .out_tlast(out_tlast)
);
